// ===== sv/lfcs_pkg.sv =====
package lfcs_pkg;

   localparam int LINE_MAX_DEFAULT = 63;

   // Range slots compared by the selector, two per 64-bit range register.
   localparam int RANGE_REGS  = 6;
   localparam int RANGE_SLOTS = 12;
   localparam int POS_W       = 16;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] TAB_BYTE     = 8'd9;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SELECT_MODE = 3'd0;
   localparam logic [2:0] CSR_FIELD_DELIM = 3'd1;
   localparam logic [2:0] CSR_RANGE_FIRST = 3'd2;
   localparam logic [2:0] CSR_RANGE_LAST  = 3'd7;

   typedef logic [RANGE_REGS-1:0][63:0] range_regs_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DRAIN_RD = 4'b0010,
      ST_DRAIN_WR = 4'b0100,
      ST_TAIL     = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load_drain;
      logic load_tail;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic drain_need;
      logic drain_last;
      logic has_tail;
   } ctrl_sts_type;

   // True when some used slot covers the position: lo != 0, lo <= pos and
   // either hi is zero (open-ended) or pos <= hi.
   function automatic logic is_selected(input range_regs_type ranges,
                                        input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic             hit;
      hit = 1'b0;
      for (int k = 0; k < RANGE_SLOTS; k++) begin
         lo = ranges[k/2][(k%2)*32 +: POS_W];
         hi = ranges[k/2][(k%2)*32 + POS_W +: POS_W];
         if ((lo != '0) && (pos >= lo) && ((hi == '0) || (pos <= hi))) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ===== sv/lfcs_ctrl.sv =====
module lfcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lfcs_pkg::ctrl_sts_type sts,
   output lfcs_pkg::ctrl_cmd_type cmd
);
   import lfcs_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.load_drain = 1'b0;
      cmd.load_tail  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.drain_need) begin
               state_in = ST_DRAIN_RD;
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_WR;
         end
         ST_DRAIN_WR: begin
            if (sts.out_free) begin
               cmd.load_drain = 1'b1;
               if (!sts.drain_last) begin
                  state_in = ST_DRAIN_RD;
               end else if (sts.has_tail) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (sts.out_free) begin
               cmd.load_tail = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE) || !sts.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_rd_then_wr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN_RD |=> state_ff == ST_DRAIN_WR)
      else $error("drain read not followed by drain write");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load_drain && sts.drain_last && !sts.has_tail |=> state_ff == ST_IDLE)
      else $error("drain without tail did not return to idle");

   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && sts.drain_need |=> state_ff == ST_DRAIN_RD)
      else $error("buffered field drain did not start");

endmodule

// ===== sv/lfcs_datapath.sv =====
module lfcs_datapath #(
   parameter int LINE_MAX = lfcs_pkg::LINE_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_stream_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   input  lfcs_pkg::ctrl_cmd_type cmd,
   output lfcs_pkg::ctrl_sts_type sts
);
   import lfcs_pkg::*;

   localparam int CPW = $clog2(LINE_MAX + 1);
   localparam int FNW = $clog2(LINE_MAX + 2);
   localparam int LW  = $clog2(LINE_MAX + 1);
   localparam int AW  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   // Configuration registers.
   logic           mode_ff,   mode_in;
   logic [7:0]     delim_ff,  delim_in;
   range_regs_type ranges_ff, ranges_in;

   // Line state.
   logic [CPW-1:0] cp_ff,  cp_in;
   logic [FNW-1:0] fn_ff,  fn_in;
   logic           ds_ff,  ds_in;
   logic           ps_ff,  ps_in;
   logic [LW-1:0]  len_ff, len_in;

   // Drain bookkeeping.
   logic [LW-1:0]  drain_len_ff, drain_len_in;
   logic [LW-1:0]  drain_idx_ff, drain_idx_in;
   logic [LW-1:0]  drain_idx_next;
   logic [7:0]     tail_byte_ff, tail_byte_in;
   logic           has_tail_ff,  has_tail_in;

   // Output register.
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff,  out_byte_in;
   logic           out_last_ff,  out_last_in;

   // First-field buffer.
   logic [7:0]     field_mem [LINE_MAX];
   logic [7:0]     rd_data_ff;

   logic           out_free;
   logic           is_nl;
   logic           is_delim;
   logic           in_line;
   logic           end_case;
   logic [CPW-1:0] cp_inc;
   logic [FNW-1:0] fn_inc;
   logic [FNW-1:0] pos_field;
   logic [POS_W-1:0] sel_pos;
   logic           sel_hit;
   logic           sel_one;
   logic           ps_mid;
   logic           emit_flag;
   logic [7:0]     emit_byte;
   logic           drain_need;
   logic           store_en;

   assign out_free = !out_valid_ff || !rsp_stall;

   assign is_nl    = req_in_byte == NEWLINE_BYTE;
   assign is_delim = req_in_byte == delim_ff;
   assign in_line  = !req_stream_end && !is_nl && (cp_ff < CPW'(LINE_MAX));
   assign end_case = req_stream_end ? (cp_ff != '0) : is_nl;
   assign cp_inc   = cp_ff + 1'b1;
   assign fn_inc   = (fn_ff <= FNW'(LINE_MAX)) ? fn_ff + 1'b1 : fn_ff;

   assign pos_field = is_delim ? fn_inc : fn_ff;
   assign sel_pos   = mode_ff ? POS_W'(pos_field) : POS_W'(cp_inc);
   assign sel_hit   = is_selected(ranges_ff, sel_pos);
   assign sel_one   = is_selected(ranges_ff, POS_W'(1));
   assign ps_mid    = ps_ff || (!ds_ff && sel_one);

   assign drain_idx_next = drain_idx_ff + 1'b1;

   // Decide what the offered item produces.
   always_comb begin
      emit_flag  = 1'b0;
      emit_byte  = req_in_byte;
      drain_need = 1'b0;
      store_en   = 1'b0;
      if (end_case) begin
         emit_flag  = 1'b1;
         emit_byte  = NEWLINE_BYTE;
         drain_need = mode_ff && !ds_ff && (len_ff != '0);
      end else if (in_line) begin
         if (!mode_ff) begin
            emit_flag = sel_hit;
         end else if (is_delim) begin
            drain_need = !ds_ff && sel_one && (len_ff != '0);
            emit_flag  = sel_hit && ps_mid;
         end else if (!ds_ff) begin
            store_en = len_ff < LW'(LINE_MAX);
         end else begin
            emit_flag = sel_hit;
         end
      end
   end

   // Line state and configuration updates.
   always_comb begin
      mode_in   = mode_ff;
      delim_in  = delim_ff;
      ranges_in = ranges_ff;
      cp_in     = cp_ff;
      fn_in     = fn_ff;
      ds_in     = ds_ff;
      ps_in     = ps_ff;
      len_in    = len_ff;
      if (csr_wr_en) begin
         unique case (csr_index) inside
            CSR_SELECT_MODE: mode_in  = csr_wdata[0];
            CSR_FIELD_DELIM: delim_in = csr_wdata[7:0];
            [CSR_RANGE_FIRST:CSR_RANGE_LAST]: begin
               ranges_in[csr_index - CSR_RANGE_FIRST] = csr_wdata;
            end
            default: ;
         endcase
      end
      if (cmd.accept) begin
         if (end_case) begin
            cp_in  = '0;
            fn_in  = FNW'(1);
            ds_in  = 1'b0;
            ps_in  = 1'b0;
            len_in = '0;
         end else if (in_line) begin
            cp_in = cp_inc;
            if (mode_ff && is_delim) begin
               ds_in = 1'b1;
               fn_in = fn_inc;
               ps_in = ps_mid || sel_hit;
            end else if (store_en) begin
               len_in = len_ff + 1'b1;
            end
         end
      end
   end

   // Drain setup and the output register.
   always_comb begin
      drain_len_in = drain_len_ff;
      drain_idx_in = drain_idx_ff;
      tail_byte_in = tail_byte_ff;
      has_tail_in  = has_tail_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.accept && drain_need) begin
         drain_len_in = len_ff;
         drain_idx_in = '0;
         tail_byte_in = emit_byte;
         has_tail_in  = emit_flag;
      end else if (cmd.accept && emit_flag) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = 1'b1;
      end
      if (cmd.load_drain) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_last_in  = sts.drain_last && !has_tail_ff;
         drain_idx_in = drain_idx_next;
      end
      if (cmd.load_tail) begin
         out_valid_in = 1'b1;
         out_byte_in  = tail_byte_ff;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         delim_ff     <= TAB_BYTE;
         ranges_ff    <= '0;
         cp_ff        <= '0;
         fn_ff        <= FNW'(1);
         ds_ff        <= 1'b0;
         ps_ff        <= 1'b0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         delim_ff     <= delim_in;
         ranges_ff    <= ranges_in;
         cp_ff        <= cp_in;
         fn_ff        <= fn_in;
         ds_ff        <= ds_in;
         ps_ff        <= ps_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drain_len_ff <= drain_len_in;
      drain_idx_ff <= drain_idx_in;
      tail_byte_ff <= tail_byte_in;
      has_tail_ff  <= has_tail_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store_en) begin
         field_mem[len_ff[AW-1:0]] <= req_in_byte;
      end
      rd_data_ff <= field_mem[drain_idx_ff[AW-1:0]];
   end

   assign sts.out_free   = out_free;
   assign sts.drain_need = drain_need;
   assign sts.drain_last = drain_idx_next == drain_len_ff;
   assign sts.has_tail   = has_tail_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_drain |-> drain_idx_ff < drain_len_ff)
      else $error("drain index ran past the buffered length");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_drain || cmd.load_tail |-> out_free)
      else $error("output register overwritten while occupied");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !cmd.load_drain && !cmd.load_tail)
      else $error("item accepted during a drain");

endmodule

// ===== sv/line_field_char_selector_top.sv =====
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_stall     req_in_byte, req_stream_end
// rsp       out        rsp_valid / rsp_stall     rsp_out_byte, rsp_last_of_run
// csr       in         csr_wr_en                 csr_index, csr_wdata
//
// An item that yields at most one byte is taken while the output register
// is free or emptied in that cycle. Draining the buffered first field does a
// registered buffer read, then an output load, for each byte, then loads a
// trailing delimiter or newline if one is due, with intake stalled meanwhile.
// Reset is synchronous and clears configuration and line state; the field
// buffer needs no clearing. A stall on rsp holds the output item and intake.
module line_field_char_selector_top #(
   parameter int LINE_MAX = lfcs_pkg::LINE_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import lfcs_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // The controller sequences the drain of the first-field buffer and the
   // byte that follows it; everything else happens on the accepting edge.
   lfcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds configuration, line counters, the field buffer and
   // the output register, and evaluates the range selection.
   lfcs_datapath #(
      .LINE_MAX (LINE_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import lfcs_pkg::*;

   // Kept line length of the block, taken from its default parameter.
   localparam int LINE_LIMIT = LINE_MAX_DEFAULT;

   // Cycles to let pass after the last expected byte before a register write
   // or before the final verdict. This covers a full first-field drain, the
   // longest run that the block can be busy with.
   localparam int SETTLE_CYCLES = 2 * LINE_LIMIT + 16;

   // Worst case per item is 64 output bytes, each read out of the field buffer
   // and possibly held by a receiver stall, plus a sender gap. Even with that
   // for every item, the run stays several times under this limit.
   localparam int CYCLE_LIMIT = 1_000_000;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 26;
   localparam logic [7:0] ALL_REGS = 8'hFF;

   typedef struct {
      logic [7:0] data;
      logic       fin;
   } text_in_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } text_out_type;

   // Clock and reset. Reset is synchronous, starts high and is released by the test sequence.
   logic clock;
   logic reset = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Every input of the block starts at a known value.
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte    = '0;
   logic        req_stream_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        csr_wr_en      = 1'b0;
   logic [2:0]  csr_index      = '0;
   logic [63:0] csr_wdata      = '0;

   line_field_char_selector_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Stimulus and scoreboard storage.
   text_in_type  bytes_to_send[$];
   text_out_type text_expected[$];
   text_out_type run_text[$];
   int        items_open    = 0;
   int        mismatches    = 0;
   int        cycle_count   = 0;
   int        send_gap_pct  = 0;
   int        hold_pct      = 0;

   // Shadow copy of the configuration registers, and the values staged for
   // the next programming pass.
   logic [63:0] cfg_regs [0:CSR_RANGE_LAST];
   logic [63:0] staged   [0:CSR_RANGE_LAST];

   // Line state of the cut engine as the testbench tracks it.
   int unsigned line_len   = 0;
   int unsigned field_idx  = 1;
   bit          sep_found  = 1'b0;
   bit          piece_open = 1'b0;
   logic [7:0]  head_field [LINE_LIMIT];
   int unsigned head_len   = 0;

   // ---------------------------------------------------------------------
   // Prediction of the cut engine.
   // ---------------------------------------------------------------------

   // A position (character or field number) is kept when any used slot covers
   // it. Slots are 32 bits wide, low bound in the lower half; a low bound of
   // zero leaves the slot unused and an upper bound of zero leaves it open.
   function automatic bit keeps_position(input int unsigned p);
      logic [31:0] slot;
      int unsigned lo;
      int unsigned hi;
      for (int s = 0; s < RANGE_SLOTS; s++) begin
         slot = 32'(cfg_regs[int'(CSR_RANGE_FIRST) + s / 2] >> (32 * (s % 2)));
         lo   = slot[15:0];
         hi   = slot[31:16];
         if (lo != 0 && p >= lo && (hi == 0 || p <= hi)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void emit_text(input logic [7:0] b);
      text_out_type t;
      t.data = b;
      t.last = 1'b0;
      run_text.push_back(t);
   endfunction

   function automatic void release_head_field();
      for (int unsigned i = 0; i < head_len; i++) emit_text(head_field[i]);
   endfunction

   // End of a line: in field mode a line that never showed a delimiter goes
   // out whole; the newline always follows.
   function automatic void close_line();
      if (cfg_regs[CSR_SELECT_MODE][0] && !sep_found) release_head_field();
      emit_text(NEWLINE_BYTE);
      line_len   = 0;
      field_idx  = 1;
      sep_found  = 1'b0;
      piece_open = 1'b0;
      head_len   = 0;
   endfunction

   // Works out the output bytes for one accepted item and queues them, with
   // the last-of-run flag on the final one.
   function automatic void cut_predict(input logic [7:0] b, input logic fin);
      text_out_type t;
      logic       field_mode;
      logic [7:0] sep;
      field_mode = cfg_regs[CSR_SELECT_MODE][0];
      sep        = cfg_regs[CSR_FIELD_DELIM][7:0];
      run_text.delete();
      if (fin) begin
         if (line_len > 0) close_line();
      end else if (b == NEWLINE_BYTE) begin
         close_line();
      end else if (line_len < LINE_LIMIT) begin
         line_len++;
         if (!field_mode) begin
            if (keeps_position(line_len)) emit_text(b);
         end else if (b == sep) begin
            // The first delimiter decides whether the buffered first field
            // is kept; every kept field after the first kept one costs one joining delimiter.
            if (!sep_found) begin
               sep_found = 1'b1;
               if (keeps_position(1)) begin
                  release_head_field();
                  piece_open = 1'b1;
               end
            end
            if (field_idx <= LINE_LIMIT) field_idx++;
            if (keeps_position(field_idx)) begin
               if (piece_open) emit_text(b);
               piece_open = 1'b1;
            end
         end else if (!sep_found) begin
            if (head_len < LINE_LIMIT) begin
               head_field[head_len] = b;
               head_len++;
            end
         end else if (keeps_position(field_idx)) begin
            emit_text(b);
         end
      end
      if (run_text.size() != 0) begin
         t = run_text.pop_back();
         t.last = 1'b1;
         run_text.push_back(t);
      end
      foreach (run_text[i]) text_expected.push_back(run_text[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: feeds pending items onto the input channel. A new item is put up
   // only when the channel is free or its item is being taken at this edge,
   // so valid and payload hold steady under a stall. After each item a random
   // idle burst may follow.
   // ---------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      text_in_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cut_predict(req_in_byte, req_stream_end);
            items_open--;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0 || bytes_to_send.size() == 0) begin
               if (send_gap != 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               nxt = bytes_to_send.pop_front();
               req_valid      <= 1'b1;
               req_in_byte    <= nxt.data;
               req_stream_end <= nxt.fin;
               if ($urandom_range(99) < send_gap_pct) send_gap = $urandom_range(4, 1);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks every accepted output byte against the oldest
   // expectation and drives the receiver's stall in random bursts.
   // ---------------------------------------------------------------------
   int hold_left = 0;

   always @(posedge clock) begin
      text_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (text_expected.size() == 0) begin
               $error("out_byte: no byte expected, got %h", rsp_out_byte);
               mismatches++;
            end else begin
               want = text_expected.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %h, got %h", want.data, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %b, got %b", want.last,
                         rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < hold_pct) begin
            hold_left = $urandom_range(3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Timeout. A hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   task automatic push_item(input logic [7:0] b, input logic fin);
      text_in_type t;
      t.data = b;
      t.fin  = fin;
      bytes_to_send.push_back(t);
      items_open++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
   endtask

   // Waits until every item has been taken and every expected byte has come
   // back, then lets the given number of cycles pass.
   task automatic wait_quiet(input int extra);
      while (items_open != 0 || text_expected.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Writes the staged value of each register selected by the mask, one per
   // cycle, keeping the write enable high across back-to-back writes.
   task automatic load_csr(input logic [7:0] mask);
      for (int r = int'(CSR_SELECT_MODE); r <= int'(CSR_RANGE_LAST); r++) begin
         if (mask[r]) begin
            csr_wr_en   <= 1'b1;
            csr_index   <= 3'(r);
            csr_wdata   <= staged[r];
            cfg_regs[r] = staged[r];
            @(posedge clock);
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [63:0] pack_pair(input logic [15:0] lo0, input logic [15:0] hi0,
                                             input logic [15:0] lo1, input logic [15:0] hi1);
      return {hi1, lo1, hi0, lo0};
   endfunction

   // One random range slot: mostly small bounds that lines actually reach,
   // with unused, open-ended, reversed and full-width bounds mixed in.
   function automatic logic [31:0] rand_slot();
      logic [15:0] lo;
      logic [15:0] hi;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 20)      lo = '0;
      else if (roll < 80) lo = 16'($urandom_range(12, 1));
      else if (roll < 93) lo = 16'($urandom_range(70, 13));
      else                lo = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 30)                  hi = '0;
      else if (roll < 75)             hi = lo + 16'($urandom_range(6));
      else if (roll < 90 && lo > 2)   hi = 16'($urandom_range(lo - 1, 1));
      else                            hi = 16'($urandom);
      return {hi, lo};
   endfunction

   // One random line: text, delimiters and the odd arbitrary byte, ended by a
   // newline or by end of input. A few lines run past the kept length, and
   // now and then an end of input follows an already finished line.
   task automatic push_random_line(input logic [7:0] sep, inout int counted);
      int         len;
      int         roll;
      logic [7:0] b;
      roll = $urandom_range(99);
      if (roll < 82)      len = $urandom_range(12);
      else if (roll < 92) len = $urandom_range(40, 13);
      else                len = $urandom_range(80, 60);
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(99);
         if (roll < 25)      b = sep;
         else if (roll < 85) b = 8'h61 + 8'($urandom_range(25));
         else                b = 8'($urandom_range(255));
         push_item(b, 1'b0);
      end
      roll = $urandom_range(99);
      if (roll < 8) push_item(8'($urandom_range(255)), 1'b1);
      else          push_item(NEWLINE_BYTE, 1'b0);
      if (roll < 3) push_item(8'($urandom_range(255)), 1'b1);
      counted += len + 1 + ((roll < 3) ? 1 : 0);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0] sep;
      int         phase_count;
      int         roll;

      // The shadow registers start at the block's reset values.
      foreach (cfg_regs[r]) cfg_regs[r] = '0;
      cfg_regs[CSR_FIELD_DELIM] = 64'(TAB_BYTE);
      foreach (staged[r]) staged[r] = cfg_regs[r];

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 20;
      hold_pct     = 20;

      // Reset configuration: character mode with every slot unused, so a
      // line gives its newline alone. An end of input with no partial line
      // gives nothing.
      push_text("ab");
      push_item(NEWLINE_BYTE, 1'b0);
      push_item(NEWLINE_BYTE, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // Character mode with a closed range, an open-ended range, a reversed
      // range and a range at the top of the 16-bit position space. The line
      // carries the byte extremes and is flushed by end of input, whose
      // byte (a newline here) must be ignored.
      staged[CSR_RANGE_FIRST]     = pack_pair(16'd2, 16'd3, 16'd5, 16'd0);
      staged[CSR_RANGE_FIRST + 1] = pack_pair(16'd9, 16'd4, 16'hFFFF, 16'hFFFF);
      load_csr(8'(1) << CSR_RANGE_FIRST | 8'(1) << (CSR_RANGE_FIRST + 1));
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item("x", 1'b0);
      push_item(TAB_BYTE, 1'b0);
      push_item(8'h80, 1'b0);
      push_item("q", 1'b0);
      push_item(8'h7F, 1'b0);
      push_item(NEWLINE_BYTE, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // Field mode with comma: fields 1..2 and 4 onward. The second field is
      // empty yet selected, so it still costs a joining delimiter.
      staged[CSR_SELECT_MODE]     = 64'd1;
      staged[CSR_FIELD_DELIM]     = 64'(",");
      staged[CSR_RANGE_FIRST]     = pack_pair(16'd1, 16'd2, 16'd4, 16'd0);
      staged[CSR_RANGE_FIRST + 1] = '0;
      load_csr(ALL_REGS);
      push_text("ab,,c,d");
      push_item(NEWLINE_BYTE, 1'b0);

      // A line with no delimiter yet is left buffered, then the mode goes
      // back to characters mid-line; the buffered bytes must be discarded.
      push_text("xyz");
      wait_quiet(SETTLE_CYCLES);
      staged[CSR_SELECT_MODE] = '0;
      load_csr(8'(1) << CSR_SELECT_MODE);
      push_item(NEWLINE_BYTE, 1'b0);
      wait_quiet(SETTLE_CYCLES);

      // Random phases. Each one programs every register, with the extremes
      // of mode, delimiter and range registers spread over the phases, and
      // sends well-formed lines with random content. Some phases run without
      // sender gaps or receiver stalls, and the last one has neither.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)      staged[CSR_SELECT_MODE] = '0;
         else if (p == 1) staged[CSR_SELECT_MODE] = {$urandom, $urandom} | 64'd1;
         else begin
            staged[CSR_SELECT_MODE] = {$urandom, $urandom};
         end

         roll = $urandom_range(2);
         case (p)
            0: sep = TAB_BYTE;
            1: sep = ",";
            2: sep = 8'h00;
            3: sep = 8'hFF;
            4: sep = NEWLINE_BYTE;
            default: sep = (roll == 0) ? 8'(" ") : 8'($urandom_range(255));
         endcase
         staged[CSR_FIELD_DELIM] = {$urandom, $urandom};
         staged[CSR_FIELD_DELIM][7:0] = sep;

         for (int k = 0; k < RANGE_REGS; k++) begin
            if (p == 5)      staged[int'(CSR_RANGE_FIRST) + k] = '1;
            else if (p == 6) staged[int'(CSR_RANGE_FIRST) + k] = '0;
            else             staged[int'(CSR_RANGE_FIRST) + k] = {rand_slot(), rand_slot()};
         end
         load_csr(ALL_REGS);

         send_gap_pct = (p % 3 == 1 || p == RANDOM_PHASES - 1) ? 0 : 30;
         hold_pct     = (p % 3 == 2 || p == RANDOM_PHASES - 1) ? 0 : 30;

         phase_count = 0;
         while (phase_count < ITEMS_PER_PHASE) push_random_line(sep, phase_count);
         wait_quiet(SETTLE_CYCLES);
      end

      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lfcs_pkg.sv
sv/lfcs_ctrl.sv
sv/lfcs_datapath.sv
sv/line_field_char_selector_top.sv
tb/testbench.sv
